// ----- hw/rtl/tmh_pkg.sv -----
// Shared types, constants and helpers for the timer task heap scheduler.
package tmh_pkg;

  localparam int TASK_SLOTS = 64;
  localparam int SLOT_W     = $clog2(TASK_SLOTS);
  localparam int CNT_W      = SLOT_W + 1;

  localparam logic [2:0] OP_ADD      = 3'd0;
  localparam logic [2:0] OP_TICK     = 3'd1;
  localparam logic [2:0] OP_RELEASE  = 3'd2;
  localparam logic [2:0] OP_KILL     = 3'd3;
  localparam logic [2:0] OP_DELAY    = 3'd4;
  localparam logic [2:0] OP_EARLIEST = 3'd5;
  localparam logic [2:0] OP_CLEAR    = 3'd6;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NONE     = 2'd2;
  localparam logic [1:0] ST_BAD_HDL  = 2'd3;

  localparam logic [1:0] REF_FREE    = 2'd0;
  localparam logic [1:0] REF_QUEUE   = 2'd1;
  localparam logic [1:0] REF_HELD    = 2'd2;

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] now;
    logic [63:0] due_or_offset;
    logic        relative;
    logic [27:0] period;
    logic        repeat_req;
    logic        keep_handle;
    logic [31:0] tag;
    logic [5:0]  handle;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot;
    logic        fired;
    logic [31:0] fired_tag;
    logic        was_killed;
    logic [63:0] time_value;
  } rsp_t;

  // Heap node: ordering on {due, slot} gives ties to the lowest slot.
  typedef struct packed {
    logic [63:0]       due;
    logic [SLOT_W-1:0] slot;
  } heap_ent_t;

  typedef struct packed {
    logic [27:0] interval;
    logic [31:0] token;
  } slot_ent_t;

  function automatic logic ent_earlier(heap_ent_t a, heap_ent_t b);
    return a < b;
  endfunction

endpackage

// ----- hw/rtl/tmh_slot_alloc.sv -----
// Lowest free slot finder over the per-slot busy vector.
module tmh_slot_alloc (
  input  logic [tmh_pkg::TASK_SLOTS-1:0] used,
  output logic                           found,
  output logic [tmh_pkg::SLOT_W-1:0]     slot
);
  import tmh_pkg::*;

  always_comb begin
    found = 1'b0;
    slot  = '0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        found = 1'b1;
        slot  = SLOT_W'(i);
      end
    end
  end

endmodule

// ----- hw/rtl/timer_task_heap_scheduler.sv -----
// Top level of the timer task heap scheduler.
// Timer tasks live in a min-heap on due time held in a one-port-read,
// one-port-write synchronous memory; per-task interval and token sit in a
// second memory indexed by slot. One command is taken while busy is low and
// start is high; its single result beat appears on result with done high for
// exactly one cycle, and the receiver cannot stall it. Release, clear and
// rejected commands answer directly from idle; queries first read the heap top.
// Add climbs the heap from the last position. Tick pops with a sift-down that
// does two child reads and a compare per level, then a sift-up when re-armed.
// Kill first scans the heap memory entry by entry, then removes and re-inserts.
// No clearing pass is needed.
module timer_task_heap_scheduler (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  tmh_pkg::cmd_t cmd,
  output logic          done,
  output tmh_pkg::rsp_t result
);
  import tmh_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_TOP_CHK, S_SLOT_USE, S_RM_START, S_RM_WAIT,
    S_DN_RDL, S_DN_RDR, S_DN_R, S_DN_CMP, S_UP_RD, S_UP_CMP,
    S_AFTER, S_FIND_RD, S_FIND_CHK
  } state_t;

  state_t              state;
  logic [CNT_W-1:0]    count;
  logic [SLOT_W-1:0]   pos;
  logic [SLOT_W-1:0]   cpos;
  logic [SLOT_W-1:0]   idx;
  logic [SLOT_W-1:0]   ps;
  heap_ent_t           mv;
  heap_ent_t           cand;
  heap_ent_t           put_entry;
  logic                put_pending;
  logic                moved;
  cmd_t                req;

  logic [1:0]          ref_cnt [TASK_SLOTS];
  logic [TASK_SLOTS-1:0] queued;
  logic [TASK_SLOTS-1:0] has_cb;
  logic [TASK_SLOTS-1:0] rep;
  logic [TASK_SLOTS-1:0] killed;

  // Heap memory: position -> {due, slot}.
  heap_ent_t           heap_mem [TASK_SLOTS];
  heap_ent_t           hrd;
  logic                hre, hwe;
  logic [SLOT_W-1:0]   hra, hwa;
  heap_ent_t           hwd;

  // Slot memory: slot -> {interval, token}.
  slot_ent_t           slot_mem [TASK_SLOTS];
  slot_ent_t           srd;
  logic                swe;

  logic [TASK_SLOTS-1:0] used;
  logic                free_found;
  logic [SLOT_W-1:0]   free_slot;

  logic [CNT_W-1:0]    lchild, rchild;
  logic [SLOT_W-1:0]   parent;
  logic [SLOT_W-1:0]   hdl;

  assign lchild = {pos, 1'b1};
  assign rchild = lchild + 1'b1;
  assign parent = (pos - 1'b1) >> 1;
  assign hdl    = req.handle[SLOT_W-1:0];
  assign busy   = (state != S_IDLE);

  always_comb begin
    for (int i = 0; i < TASK_SLOTS; i++) used[i] = (ref_cnt[i] != REF_FREE);
  end

  tmh_slot_alloc u_alloc (
    .used  (used),
    .found (free_found),
    .slot  (free_slot)
  );

  // Heap memory port control, driven from the sequencer state.
  always_comb begin
    hre = 1'b0;
    hra = '0;
    hwe = 1'b0;
    hwa = pos;
    hwd = mv;
    case (state)
      S_IDLE: begin
        hre = start;
      end
      S_RM_START: begin
        hre = 1'b1;
        hra = count[SLOT_W-1:0];
      end
      S_DN_RDL: begin
        hre = 1'b1;
        hra = lchild[SLOT_W-1:0];
        if (lchild >= count && moved) hwe = 1'b1;
      end
      S_DN_RDR: begin
        hre = 1'b1;
        hra = rchild[SLOT_W-1:0];
      end
      S_DN_CMP: begin
        if (ent_earlier(cand, mv)) begin
          hwe = 1'b1;
          hwd = cand;
        end else if (moved) begin
          hwe = 1'b1;
        end
      end
      S_UP_RD: begin
        if (pos == '0) begin
          hwe = 1'b1;
        end else begin
          hre = 1'b1;
          hra = parent;
        end
      end
      S_UP_CMP: begin
        hwe = 1'b1;
        if (ent_earlier(mv, hrd)) hwd = hrd;
      end
      S_FIND_RD: begin
        hre = 1'b1;
        hra = idx;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (hwe) heap_mem[hwa] <= hwd;
    if (hre) hrd <= heap_mem[hra];
  end

  assign swe = (state == S_IDLE) && start && (cmd.op == OP_ADD) && free_found;

  always_ff @(posedge clk) begin
    if (swe) slot_mem[free_slot] <= '{interval: cmd.period, token: cmd.tag};
    if (state == S_TOP_CHK) srd <= slot_mem[hrd.slot];
  end

  // Sequencer: one command at a time through the heap memory.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      done        <= 1'b0;
      put_pending <= 1'b0;
      queued      <= '0;
      for (int i = 0; i < TASK_SLOTS; i++) ref_cnt[i] <= REF_FREE;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            req         <= cmd;
            result      <= '0;
            put_pending <= 1'b0;
            case (cmd.op)
              OP_ADD: begin
                if (!free_found) begin
                  result.status <= ST_FULL;
                  done          <= 1'b1;
                end else begin
                  ref_cnt[free_slot] <= cmd.keep_handle ? REF_HELD : REF_QUEUE;
                  queued[free_slot]  <= 1'b1;
                  rep[free_slot]     <= cmd.repeat_req;
                  killed[free_slot]  <= 1'b0;
                  has_cb[free_slot]  <= 1'b1;
                  mv.due  <= cmd.relative ? cmd.now + cmd.due_or_offset
                                          : cmd.due_or_offset;
                  mv.slot <= free_slot;
                  pos     <= count[SLOT_W-1:0];
                  count   <= count + 1'b1;
                  result.slot <= 6'(free_slot);
                  state   <= S_UP_RD;
                end
              end
              OP_TICK, OP_DELAY, OP_EARLIEST: begin
                if (count == '0) begin
                  result.status <= ST_NONE;
                  if (cmd.op != OP_TICK) result.time_value <= '1;
                  done <= 1'b1;
                end else begin
                  state <= S_TOP_CHK;
                end
              end
              OP_RELEASE: begin
                if (ref_cnt[cmd.handle[SLOT_W-1:0]] == REF_FREE) begin
                  result.status <= ST_BAD_HDL;
                end else if (ref_cnt[cmd.handle[SLOT_W-1:0]] == REF_HELD) begin
                  ref_cnt[cmd.handle[SLOT_W-1:0]] <= REF_QUEUE;
                  has_cb[cmd.handle[SLOT_W-1:0]]  <= 1'b0;
                  rep[cmd.handle[SLOT_W-1:0]]     <= 1'b0;
                end else if (queued[cmd.handle[SLOT_W-1:0]]) begin
                  result.status <= ST_BAD_HDL;
                end else begin
                  ref_cnt[cmd.handle[SLOT_W-1:0]] <= REF_FREE;
                end
                done <= 1'b1;
              end
              OP_KILL: begin
                if (ref_cnt[cmd.handle[SLOT_W-1:0]] != REF_HELD ||
                    !queued[cmd.handle[SLOT_W-1:0]]) begin
                  result.status <= ST_BAD_HDL;
                  done <= 1'b1;
                end else begin
                  idx   <= '0;
                  state <= S_FIND_RD;
                end
              end
              OP_CLEAR: begin
                count  <= '0;
                queued <= '0;
                for (int i = 0; i < TASK_SLOTS; i++) ref_cnt[i] <= REF_FREE;
                done   <= 1'b1;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_TOP_CHK: begin
          // Top of heap is on the memory read port.
          case (req.op)
            OP_DELAY: begin
              result.time_value <= (hrd.due > req.now) ? hrd.due - req.now : '0;
              done  <= 1'b1;
              state <= S_IDLE;
            end
            OP_EARLIEST: begin
              result.time_value <= hrd.due;
              done  <= 1'b1;
              state <= S_IDLE;
            end
            default: begin
              if (hrd.due > req.now) begin
                result.status <= ST_NONE;
                done  <= 1'b1;
                state <= S_IDLE;
              end else begin
                ps    <= hrd.slot;
                state <= S_SLOT_USE;
              end
            end
          endcase
        end
        S_SLOT_USE: begin
          if (has_cb[ps]) begin
            result.fired      <= 1'b1;
            result.fired_tag  <= srd.token;
            result.was_killed <= killed[ps];
          end
          if (rep[ps]) begin
            // Re-arm: requeue after the pop completes.
            put_pending    <= 1'b1;
            put_entry.due  <= req.now + 64'(srd.interval);
            put_entry.slot <= ps;
          end else begin
            queued[ps]  <= 1'b0;
            ref_cnt[ps] <= (ref_cnt[ps] > REF_QUEUE) ? ref_cnt[ps] - 1'b1 : REF_FREE;
          end
          count <= count - 1'b1;
          pos   <= '0;
          state <= S_RM_START;
        end
        S_RM_START: begin
          // Move the last node into the hole, or drop the hole if it was last.
          state <= ({1'b0, pos} < count) ? S_RM_WAIT : S_AFTER;
        end
        S_RM_WAIT: begin
          mv    <= hrd;
          moved <= 1'b0;
          state <= S_DN_RDL;
        end
        S_DN_RDL: begin
          if (lchild >= count) begin
            state <= moved ? S_AFTER : S_UP_RD;
          end else begin
            state <= S_DN_RDR;
          end
        end
        S_DN_RDR: begin
          cand  <= hrd;
          cpos  <= lchild[SLOT_W-1:0];
          state <= (rchild < count) ? S_DN_R : S_DN_CMP;
        end
        S_DN_R: begin
          if (ent_earlier(hrd, cand)) begin
            cand <= hrd;
            cpos <= rchild[SLOT_W-1:0];
          end
          state <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (ent_earlier(cand, mv)) begin
            pos   <= cpos;
            moved <= 1'b1;
            state <= S_DN_RDL;
          end else begin
            state <= moved ? S_AFTER : S_UP_RD;
          end
        end
        S_UP_RD: begin
          state <= (pos == '0) ? S_AFTER : S_UP_CMP;
        end
        S_UP_CMP: begin
          if (ent_earlier(mv, hrd)) begin
            pos   <= parent;
            state <= S_UP_RD;
          end else begin
            state <= S_AFTER;
          end
        end
        S_AFTER: begin
          if (put_pending) begin
            put_pending <= 1'b0;
            mv          <= put_entry;
            pos         <= count[SLOT_W-1:0];
            count       <= count + 1'b1;
            state       <= S_UP_RD;
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_FIND_RD: begin
          state <= S_FIND_CHK;
        end
        S_FIND_CHK: begin
          if (hrd.slot == hdl) begin
            killed[hdl]    <= 1'b1;
            rep[hdl]       <= 1'b0;
            put_pending    <= 1'b1;
            put_entry.due  <= req.now;
            put_entry.slot <= hdl;
            count          <= count - 1'b1;
            pos            <= idx;
            state          <= S_RM_START;
          end else if ({1'b0, idx} + 1'b1 >= count) begin
            result.status <= ST_BAD_HDL;
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_FIND_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/tmh_checker.sv -----
// Port-level checks for the timer task heap scheduler, bound to the top level.
module tmh_assertions (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input tmh_pkg::rsp_t result
);
  import tmh_pkg::*;

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while busy");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !busy && !start |=> !done)
    else $error("result beat without a command");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done)
    else $error("accepted command neither worked nor answered");

  a_fire_clean: assert property (@(posedge clk) disable iff (rst)
    done && !result.fired |-> result.fired_tag == '0 && !result.was_killed)
    else $error("fire fields set without a firing");

  a_full_slot: assert property (@(posedge clk) disable iff (rst)
    done && result.status == ST_FULL |-> result.slot == '0)
    else $error("rejected add reports a slot");

endmodule

bind timer_task_heap_scheduler tmh_assertions u_tmh_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

// ----- tb/tmh_checker.sv -----
// Checker for the timer task heap scheduler: predicts each command's result and compares.
module tmh_checker
  import tmh_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  cmd_t cmd,
  input  logic done,
  input  rsp_t result,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [63:0] due_q [TASK_SLOTS];
  logic [27:0] ival_q [TASK_SLOTS];
  logic        rep_q [TASK_SLOTS];
  logic        kill_q [TASK_SLOTS];
  logic [1:0]  refs_q [TASK_SLOTS];
  logic [31:0] token_q [TASK_SLOTS];
  logic        cb_q [TASK_SLOTS];
  int          order_q [TASK_SLOTS];
  int          heap_n;

  rsp_t expected_rsp [$];

  assign pending = expected_rsp.size();

  function automatic bit ahead(int a, int b);
    if (due_q[a] != due_q[b]) return due_q[a] < due_q[b];
    return a < b;
  endfunction

  function automatic void swap_at(int i, int j);
    int t;
    t = order_q[i];
    order_q[i] = order_q[j];
    order_q[j] = t;
  endfunction

  function automatic void climb(int pos);
    int par;
    while (pos > 0) begin
      par = (pos - 1) / 2;
      if (!ahead(order_q[pos], order_q[par])) break;
      swap_at(pos, par);
      pos = par;
    end
  endfunction

  function automatic void sink(int pos);
    int l, c;
    forever begin
      l = 2 * pos + 1;
      if (l >= heap_n) break;
      c = l;
      if (l + 1 < heap_n && ahead(order_q[l+1], order_q[l])) c = l + 1;
      if (!ahead(order_q[c], order_q[pos])) break;
      swap_at(pos, c);
      pos = c;
    end
  endfunction

  function automatic void push(int s);
    if (heap_n >= TASK_SLOTS) return;
    order_q[heap_n] = s;
    heap_n++;
    climb(heap_n - 1);
  endfunction

  function automatic void pull_at(int i);
    if (i >= heap_n) return;
    heap_n--;
    if (i < heap_n) begin
      order_q[i] = order_q[heap_n];
      sink(i);
      climb(i);
    end
  endfunction

  function automatic int locate(int s);
    for (int i = 0; i < heap_n; i++) if (order_q[i] == s) return i;
    return TASK_SLOTS;
  endfunction

  // Advance the scheduler image by one command and return its result.
  function automatic rsp_t schedule_step(cmd_t c);
    rsp_t r;
    int s, pos, h;
    r = '0;
    h = c.handle;
    case (c.op)
      OP_ADD: begin
        s = 0;
        while (s < TASK_SLOTS && refs_q[s] != REF_FREE) s++;
        if (s >= TASK_SLOTS) begin
          r.status = ST_FULL;
        end else begin
          refs_q[s]  = c.keep_handle ? REF_HELD : REF_QUEUE;
          due_q[s]   = c.relative ? c.now + c.due_or_offset : c.due_or_offset;
          ival_q[s]  = c.period;
          rep_q[s]   = c.repeat_req;
          kill_q[s]  = 1'b0;
          token_q[s] = c.tag;
          cb_q[s]    = 1'b1;
          push(s);
          r.slot = 6'(s);
        end
      end
      OP_TICK: begin
        if (heap_n == 0 || due_q[order_q[0]] > c.now) begin
          r.status = ST_NONE;
        end else begin
          s = order_q[0];
          pull_at(0);
          if (cb_q[s]) begin
            r.fired = 1'b1;
            r.fired_tag = token_q[s];
            r.was_killed = kill_q[s];
          end
          if (rep_q[s]) begin
            due_q[s] = c.now + 64'(ival_q[s]);
            push(s);
          end else if (refs_q[s] > 1) begin
            refs_q[s]--;
          end else begin
            refs_q[s] = REF_FREE;
          end
        end
      end
      OP_RELEASE: begin
        if (refs_q[h] == REF_FREE) begin
          r.status = ST_BAD_HDL;
        end else if (refs_q[h] > 1) begin
          refs_q[h]--;
          cb_q[h] = 1'b0;
          token_q[h] = '0;
          rep_q[h] = 1'b0;
        end else if (locate(h) < TASK_SLOTS) begin
          r.status = ST_BAD_HDL;
        end else begin
          refs_q[h] = REF_FREE;
        end
      end
      OP_KILL: begin
        pos = (refs_q[h] == REF_HELD) ? locate(h) : TASK_SLOTS;
        if (pos >= TASK_SLOTS) begin
          r.status = ST_BAD_HDL;
        end else begin
          pull_at(pos);
          kill_q[h] = 1'b1;
          rep_q[h] = 1'b0;
          due_q[h] = c.now;
          push(h);
        end
      end
      OP_DELAY: begin
        if (heap_n == 0) begin
          r.status = ST_NONE;
          r.time_value = '1;
        end else begin
          s = order_q[0];
          r.time_value = due_q[s] > c.now ? due_q[s] - c.now : 64'd0;
        end
      end
      OP_EARLIEST: begin
        if (heap_n == 0) begin
          r.status = ST_NONE;
          r.time_value = '1;
        end else begin
          r.time_value = due_q[order_q[0]];
        end
      end
      OP_CLEAR: begin
        heap_n = 0;
        foreach (refs_q[i]) refs_q[i] = REF_FREE;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    heap_n = 0;
    foreach (refs_q[i]) begin
      refs_q[i] = REF_FREE;
      due_q[i] = '0; ival_q[i] = '0; rep_q[i] = 0; kill_q[i] = 0;
      token_q[i] = '0; cb_q[i] = 0; order_q[i] = 0;
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (done) begin
        if (expected_rsp.size() == 0) begin
          report("unexpected beat", 64'd1, 64'd0);
        end else begin
          want = expected_rsp.pop_front();
          if (result.status !== want.status) report("status", result.status, want.status);
          if (result.slot !== want.slot) report("slot", result.slot, want.slot);
          if (result.fired !== want.fired) report("fired", result.fired, want.fired);
          if (result.fired_tag !== want.fired_tag)
            report("fired_tag", result.fired_tag, want.fired_tag);
          if (result.was_killed !== want.was_killed)
            report("was_killed", result.was_killed, want.was_killed);
          if (result.time_value !== want.time_value)
            report("time_value", result.time_value, want.time_value);
        end
      end
      if (start && !busy) expected_rsp.push_back(schedule_step(cmd));
    end
  end

endmodule

// ----- tb/tb_timer_task_heap_scheduler.sv -----
// Stimulus and verdict for the timer task heap scheduler testbench.
module tb_timer_task_heap_scheduler;
  import tmh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCH_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  cmd_t cmd = '0;
  rsp_t result;
  int   fail_count, pending;
  int   idle_pct = 17;
  int   quiet_cycles = 0;
  logic [63:0] clock_ms = 64'd1000;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  timer_task_heap_scheduler uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .done(done), .result(result)
  );

  tmh_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .result(result), .fail_count(fail_count), .pending(pending)
  );

  // Watchdog: count cycles with neither a command nor a result beat.
  always @(posedge clk) begin
    if ((start && !busy) || done || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Hold start until the beat is taken, then drop it unless idling is skipped.
  task automatic send(cmd_t c);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
  endtask

  function automatic cmd_t blank(logic [2:0] op);
    cmd_t c;
    c = '0;
    c.op = op;
    c.now = clock_ms;
    return c;
  endfunction

  function automatic cmd_t add_cmd(logic [63:0] due, logic rel, logic [27:0] per,
                                   logic rep, logic keep, logic [31:0] tag);
    cmd_t c;
    c = blank(OP_ADD);
    c.due_or_offset = due; c.relative = rel; c.period = per;
    c.repeat_req = rep; c.keep_handle = keep; c.tag = tag;
    return c;
  endfunction

  // Random command weighted toward adds and ticks, with time mostly moving forward.
  function automatic cmd_t random_cmd();
    cmd_t c;
    int pick;
    pick = $urandom_range(99);
    if ($urandom_range(9) == 0) clock_ms = {$urandom, $urandom};
    else clock_ms = clock_ms + $urandom_range(40);
    if (pick < 35) begin
      c = add_cmd($urandom_range(3) == 0 ? {$urandom, $urandom} : 64'($urandom_range(80)),
                  $urandom_range(3) != 0,
                  $urandom_range(4) == 0 ? 28'($urandom) : 28'($urandom_range(60)),
                  1'($urandom_range(1)), 1'($urandom_range(1)), $urandom);
      if ($urandom_range(1)) c.handle = 6'($urandom);
    end else if (pick < 65) c = blank(OP_TICK);
    else if (pick < 75) c = blank(OP_RELEASE);
    else if (pick < 85) c = blank(OP_KILL);
    else if (pick < 91) c = blank(OP_DELAY);
    else if (pick < 97) c = blank(OP_EARLIEST);
    else if (pick < 98) c = blank(OP_CLEAR);
    else c = blank(3'd7);
    if (c.op != OP_ADD) begin
      c.handle = 6'($urandom);
      if ($urandom_range(3) == 0) begin
        c.due_or_offset = {$urandom, $urandom};
        c.tag = $urandom; c.period = 28'($urandom);
      end
    end
    return c;
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty queries, extremes, ties, kill, release, wrap, full store.
    send(blank(OP_TICK));
    send(blank(OP_DELAY));
    send(blank(OP_EARLIEST));
    send(blank(OP_RELEASE));
    send(add_cmd(64'd1000, 1'b0, 28'd0, 1'b0, 1'b1, 32'hFFFF_FFFF));
    send(add_cmd(64'd1000, 1'b0, '1, 1'b1, 1'b1, 32'h0));
    send(add_cmd('1, 1'b1, 28'd5, 1'b0, 1'b0, 32'hA5A5_5A5A));
    send(blank(OP_EARLIEST));
    send(blank(OP_DELAY));
    begin cmd_t k; k = blank(OP_KILL); k.handle = 6'd2; send(k); end
    begin cmd_t k; k = blank(OP_KILL); k.handle = 6'd1; send(k); end
    send(blank(OP_TICK));
    send(blank(OP_TICK));
    send(blank(OP_TICK));
    begin cmd_t k; k = blank(OP_RELEASE); k.handle = 6'd0; send(k); end
    begin cmd_t k; k = blank(OP_RELEASE); k.handle = 6'd1; send(k); end
    clock_ms = '1;
    send(blank(OP_TICK));
    send(blank(OP_DELAY));
    send(blank(OP_CLEAR));
    send(blank(3'd7));
    for (int i = 0; i < 65; i++) send(add_cmd(64'(i), 1'b0, 28'd1, 1'b0, 1'b0, 32'(i)));
    send(blank(OP_CLEAR));

    // Pause until every outstanding result is back.
    start <= 1'b0;
    while (pending != 0) @(posedge clk);

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 17 : (phase == 1) ? 74 : 0;
      for (int n = 0; n < 500; n++) send(random_cmd());
    end

    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
